@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files; included by the top level.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/gsa_pkg.sv @@
// Types and constants for the grid step arpeggiator.
// No dependencies.
package gsa_pkg;

	localparam logic [1:0] MODE_DOWN = 2'd0;
	localparam logic [1:0] MODE_UP   = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	localparam logic [1:0] KIND_LED = 2'd0;
	localparam logic [1:0] KIND_ON  = 2'd1;
	localparam logic [1:0] KIND_OFF = 2'd2;

	localparam logic [1:0] COLOR_OFF    = 2'd0;
	localparam logic [1:0] COLOR_GREEN  = 2'd1;
	localparam logic [1:0] COLOR_RED    = 2'd2;
	localparam logic [1:0] COLOR_YELLOW = 2'd3;

	localparam logic [3:0] SIDE_COL = 4'd8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIV  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_NOTE = 2'd1;

	localparam logic [7:0] TICK_DIV_RESET  = 8'd6;
	localparam logic [6:0] BASE_NOTE_RESET = 7'd36;

	typedef enum logic [1:0] {
		CMD_EDIT_STEP,
		CMD_EDIT_CELL,
		CMD_STEP
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [2:0] row;
		logic [2:0] col;
		logic [1:0] shift;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] led_row;
		logic [2:0] led_col;
		logic [1:0] color;
		logic [6:0] note;
		logic       last;
	} res_t;

endpackage

@@ hw/rtl/gsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/gsa_fifo.sv @@
// Small register FIFO, used for the command queue and the result queue.
// No dependencies. DEPTH must be a power of two.
module gsa_fifo #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == (AW+1)'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

@@ hw/rtl/gsa_front.sv @@
// Front end: accepts grid events, keeps shift color and tick count,
// and queues edit and step commands. Depends on gsa_pkg.
module gsa_front
	import gsa_pkg::*;
#(
	parameter int GRID_CELLS = 48,
	parameter int STEPS      = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] mode,
	input  logic [2:0] row,
	input  logic [3:0] col,
	input  logic [7:0] tick_div,
	output logic       cmd_push,
	output cmd_t       cmd_data,
	input  logic       cmd_full
);
	logic [1:0] shift_q;
	logic [7:0] tick_cnt_q;
	logic       accept;
	logic       want_cmd;
	logic [3:0] step_idx;
	logic [5:0] cell_idx;
	logic [8:0] tick_next;
	logic [8:0] tick_lim;
	logic       step_now;
	logic [1:0] side_shift;

	assign full      = cmd_full;
	assign accept    = push && !cmd_full;
	assign step_idx  = {row[0], col[2:0]};
	assign cell_idx  = {row, col[2:0]};
	assign tick_next = {1'b0, tick_cnt_q} + 9'd1;
	assign tick_lim  = (tick_div == 8'd0) ? 9'd256 : {1'b0, tick_div};
	assign step_now  = tick_next >= tick_lim;

	always_comb begin
		case (row)
			3'd5:    side_shift = COLOR_YELLOW;
			3'd6:    side_shift = COLOR_GREEN;
			3'd7:    side_shift = COLOR_RED;
			default: side_shift = COLOR_OFF;
		endcase
	end

	always_comb begin
		want_cmd       = 1'b0;
		cmd_data.op    = CMD_STEP;
		cmd_data.row   = row;
		cmd_data.col   = col[2:0];
		cmd_data.shift = shift_q;
		unique case (mode)
			MODE_DOWN: begin
				if (!col[3]) begin
					if (row >= 3'd6) begin
						cmd_data.op = CMD_EDIT_STEP;
						want_cmd    = 5'(step_idx) < 5'(STEPS);
					end else begin
						cmd_data.op = CMD_EDIT_CELL;
						want_cmd    = 7'(cell_idx) < 7'(GRID_CELLS);
					end
				end
			end
			MODE_TICK: begin
				want_cmd = step_now;
			end
			default: begin
			end
		endcase
	end

	assign cmd_push = accept && want_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= COLOR_OFF;
			tick_cnt_q <= '0;
		end else if (accept) begin
			unique case (mode)
				MODE_DOWN: begin
					if (col == SIDE_COL) begin
						shift_q <= side_shift;
					end
				end
				MODE_UP: begin
					if (col == SIDE_COL) begin
						shift_q <= COLOR_OFF;
					end
				end
				MODE_TICK: begin
					tick_cnt_q <= step_now ? 8'd0 : tick_next[7:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/gsa_back.sv @@
// Back end: executes edit and step commands against the pattern and
// note-enable RAMs, runs the round-robin note scans. Depends on gsa_pkg, gsa_ram.
module gsa_back
	import gsa_pkg::*;
#(
	parameter int GRID_CELLS = 48,
	parameter int STEPS      = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] base_note,
	input  cmd_t       cmd_rdata,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	output logic       res_push,
	output res_t       res_data,
	input  logic       res_full
);
	localparam int CW     = $clog2(GRID_CELLS);
	localparam int SW     = $clog2(STEPS);
	localparam int TopRow = (GRID_CELLS + 7) / 8 - 1;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_EDIT_RD = 10'b0000000010,
		S_EDIT_WR = 10'b0000000100,
		S_OLD_RD  = 10'b0000001000,
		S_OLD_LED = 10'b0000010000,
		S_NEW_RD  = 10'b0000100000,
		S_NEW_LED = 10'b0001000000,
		S_VOFF    = 10'b0010000000,
		S_SCAN    = 10'b0100000000,
		S_FLUSH   = 10'b1000000000
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	res_t            pend_q;
	logic [1:0]      pat_q;
	logic            vsel_q;
	logic [CW-1:0]   gptr_q, rptr_q;
	logic [6:0]      gheld_q, rheld_q;
	logic [SW-1:0]   step_pos_q;
	logic [CW-1:0]   ia_q;
	logic [CW:0]     iss_cnt_q;
	logic            rd_vld_s1, rd_last_s1;
	logic [CW-1:0]   rd_addr_s1;
	logic [STEPS-1:0]      s_vld_q;
	logic [GRID_CELLS-1:0] c_vld_q;
	logic            s_vld_s1, c_vld_s1;

	logic            s_we, s_re, c_we, c_re;
	logic [SW-1:0]   s_raddr;
	logic [CW-1:0]   c_raddr;
	logic [1:0]      s_rdata, c_rdata, s_eff, c_eff;
	logic [SW-1:0]   step_addr, step_next;
	logic [CW-1:0]   cell_addr;
	logic [1:0]      edit_old, edit_new, mask;
	logic [CW-1:0]   cur_ptr;
	logic [6:0]      cur_held;
	logic            hit, issue, out_ok, pat_bit;
	logic [6:0]      cell7, nrow, note_calc;

	function automatic res_t mk_led(input logic [SW-1:0] p, input logic [1:0] colr);
		res_t r;
		logic [3:0] p4;
		p4        = 4'(p);
		r.kind    = KIND_LED;
		r.led_row = p4[3] ? 3'd7 : 3'd6;
		r.led_col = p4[2:0];
		r.color   = colr;
		r.note    = '0;
		r.last    = 1'b0;
		return r;
	endfunction

	function automatic res_t mk_note(input logic [1:0] k, input logic [6:0] n);
		res_t r;
		r.kind    = k;
		r.led_row = '0;
		r.led_col = '0;
		r.color   = COLOR_OFF;
		r.note    = n;
		r.last    = 1'b0;
		return r;
	endfunction

	function automatic logic [CW-1:0] cell_next(input logic [CW-1:0] p);
		return (p == CW'(GRID_CELLS - 1)) ? '0 : p + CW'(1);
	endfunction

	gsa_ram #(.WIDTH(2), .DEPTH(STEPS)) u_step_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (step_addr),
		.wdata (edit_new),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	gsa_ram #(.WIDTH(2), .DEPTH(GRID_CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (cell_addr),
		.wdata (edit_new),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	assign s_eff     = s_vld_s1 ? s_rdata : COLOR_OFF;
	assign c_eff     = c_vld_s1 ? c_rdata : COLOR_OFF;
	assign step_addr = SW'({cmd_q.row[0], cmd_q.col});
	assign cell_addr = CW'({cmd_q.row, cmd_q.col});
	assign step_next = (step_pos_q == SW'(STEPS - 1)) ? '0 : step_pos_q + SW'(1);
	assign edit_old  = (cmd_q.op == CMD_EDIT_STEP) ? s_eff : c_eff;
	assign edit_new  = (cmd_q.shift != COLOR_OFF && edit_old != cmd_q.shift) ? cmd_q.shift :
		(edit_old != COLOR_OFF) ? COLOR_OFF : COLOR_GREEN;
	assign mask      = vsel_q ? COLOR_RED : COLOR_GREEN;
	assign cur_ptr   = vsel_q ? rptr_q : gptr_q;
	assign cur_held  = vsel_q ? rheld_q : gheld_q;
	assign pat_bit   = (pat_q & mask) == mask;
	assign out_ok    = !res_full;
	assign hit       = (state_q == S_SCAN) && rd_vld_s1 && ((c_eff & mask) == mask);
	assign issue     = (state_q == S_SCAN) && !hit && (iss_cnt_q != (CW+1)'(GRID_CELLS));

	// note = base + (top_row - row) * 8 + col, modulo 128
	assign cell7     = 7'(rd_addr_s1);
	assign nrow      = 7'(TopRow) - {3'b000, cell7[6:3]};
	assign note_calc = base_note + {nrow[3:0], 3'b000} + {4'b0000, cell7[2:0]};

	always_comb begin
		cmd_pop  = 1'b0;
		s_we     = 1'b0;
		s_re     = 1'b0;
		s_raddr  = step_pos_q;
		c_we     = 1'b0;
		c_re     = 1'b0;
		c_raddr  = ia_q;
		res_push = 1'b0;
		res_data = pend_q;
		unique case (state_q)
			S_IDLE: begin
				cmd_pop = !cmd_empty;
			end
			S_EDIT_RD: begin
				if (cmd_q.op == CMD_EDIT_STEP) begin
					s_re    = 1'b1;
					s_raddr = step_addr;
				end else begin
					c_re    = 1'b1;
					c_raddr = cell_addr;
				end
			end
			S_EDIT_WR: begin
				res_data.kind    = KIND_LED;
				res_data.led_row = cmd_q.row;
				res_data.led_col = cmd_q.col;
				res_data.color   = edit_new;
				res_data.note    = '0;
				res_data.last    = 1'b1;
				if (out_ok) begin
					res_push = 1'b1;
					s_we     = cmd_q.op == CMD_EDIT_STEP;
					c_we     = cmd_q.op != CMD_EDIT_STEP;
				end
			end
			S_OLD_RD, S_NEW_RD: begin
				s_re = 1'b1;
			end
			S_NEW_LED: begin
				res_push = out_ok;
			end
			S_VOFF: begin
				res_push = out_ok && cur_held != '0;
			end
			S_SCAN: begin
				c_re     = issue;
				res_push = hit && out_ok;
			end
			S_FLUSH: begin
				res_data.last = 1'b1;
				res_push      = out_ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			vsel_q     <= 1'b0;
			gptr_q     <= CW'(GRID_CELLS - 1);
			rptr_q     <= CW'(GRID_CELLS - 1);
			gheld_q    <= '0;
			rheld_q    <= '0;
			step_pos_q <= '0;
			ia_q       <= '0;
			iss_cnt_q  <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			rd_addr_s1 <= '0;
			s_vld_q    <= '0;
			c_vld_q    <= '0;
			s_vld_s1   <= 1'b0;
			c_vld_s1   <= 1'b0;
		end else begin
			if (s_re) begin
				s_vld_s1 <= s_vld_q[s_raddr];
			end
			if (c_re) begin
				c_vld_s1 <= c_vld_q[c_raddr];
			end
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						state_q <= (cmd_rdata.op == CMD_STEP) ? S_OLD_RD : S_EDIT_RD;
					end
				end
				S_EDIT_RD: begin
					state_q <= S_EDIT_WR;
				end
				S_EDIT_WR: begin
					if (out_ok) begin
						if (cmd_q.op == CMD_EDIT_STEP) begin
							s_vld_q[step_addr] <= 1'b1;
						end else begin
							c_vld_q[cell_addr] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_OLD_RD: begin
					state_q <= S_OLD_LED;
				end
				S_OLD_LED: begin
					step_pos_q <= step_next;
					state_q    <= S_NEW_RD;
				end
				S_NEW_RD: begin
					state_q <= S_NEW_LED;
				end
				S_NEW_LED: begin
					if (out_ok) begin
						vsel_q  <= 1'b0;
						state_q <= S_VOFF;
					end
				end
				S_VOFF: begin
					if (cur_held == '0 || out_ok) begin
						if (vsel_q) begin
							rheld_q <= '0;
						end else begin
							gheld_q <= '0;
						end
						if (pat_bit) begin
							ia_q      <= cell_next(cur_ptr);
							iss_cnt_q <= '0;
							state_q   <= S_SCAN;
						end else if (!vsel_q) begin
							vsel_q <= 1'b1;
						end else begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						ia_q      <= cell_next(ia_q);
						iss_cnt_q <= iss_cnt_q + (CW+1)'(1);
					end
					if ((hit && out_ok) || (rd_vld_s1 && !hit && rd_last_s1)) begin
						rd_vld_s1 <= 1'b0;
						if (vsel_q) begin
							rptr_q  <= hit ? rd_addr_s1 : CW'(GRID_CELLS - 1);
							rheld_q <= hit ? note_calc : rheld_q;
							state_q <= S_FLUSH;
						end else begin
							gptr_q  <= hit ? rd_addr_s1 : CW'(GRID_CELLS - 1);
							gheld_q <= hit ? note_calc : gheld_q;
							vsel_q  <= 1'b1;
							state_q <= S_VOFF;
						end
					end else if (!hit) begin
						rd_vld_s1  <= issue;
						rd_addr_s1 <= ia_q;
						rd_last_s1 <= iss_cnt_q == (CW+1)'(GRID_CELLS - 1);
					end
				end
				S_FLUSH: begin
					if (out_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && !cmd_empty) begin
			cmd_q <= cmd_rdata;
		end
		if (state_q == S_OLD_LED) begin
			pend_q <= mk_led(step_pos_q, s_eff);
		end
		if (state_q == S_NEW_LED && out_ok) begin
			pend_q <= mk_led(step_pos_q, COLOR_YELLOW);
			pat_q  <= s_eff;
		end
		if (state_q == S_VOFF && out_ok && cur_held != '0) begin
			pend_q <= mk_note(KIND_OFF, cur_held);
		end
		if (hit && out_ok) begin
			pend_q <= mk_note(KIND_ON, note_calc);
		end
	end

endmodule

@@ hw/rtl/grid_step_arpeggiator.sv @@
// Top level of the grid step arpeggiator: config registers, front end,
// command queue, back end and result queue. Depends on gsa_pkg and all gsa_* modules.
//
// Grid key events and clock ticks go in through a queue-style push/full port; LED
// writes and note on/off results come out through an empty/pop port, last marking
// the final result of an event. A key edit passes the back-end states for command pop,
// RAM read, and write with its LED beat. A sequencer step writes the old and new step
// LEDs, releases each color's held note and, per active color, runs one scan that
// reads the note-enable RAM one cell per cycle, a rate set by the single read port of
// that RAM. A full result queue stalls the back end wherever it writes a result.
// Front end and back end are parted by a 4-deep command queue, results by a
// 4-deep queue. Both stores start cleared through per-entry valid bits, so no
// clearing pass follows reset. Configuration (index 0 tick divisor, index 1 base
// note) is taken every cycle and should be written only while no event is in flight.
`include "assert_macros.svh"

module grid_step_arpeggiator
	import gsa_pkg::*;
#(
	parameter int GRID_CELLS = 48,
	parameter int STEPS      = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           mode,
	input  logic [2:0]           row,
	input  logic [3:0]           col,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           kind,
	output logic [2:0]           led_row,
	output logic [2:0]           led_col,
	output logic [1:0]           color,
	output logic [6:0]           note,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);
	logic [7:0] tick_div_q;
	logic [6:0] base_note_q;
	logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t       cmd_wdata, cmd_rdata;
	logic       res_push, res_full;
	res_t       res_wdata, res_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_div_q  <= TICK_DIV_RESET;
			base_note_q <= BASE_NOTE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TICK_DIV:  tick_div_q  <= cfg_data;
				CFG_BASE_NOTE: base_note_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	gsa_front #(.GRID_CELLS(GRID_CELLS), .STEPS(STEPS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.mode     (mode),
		.row      (row),
		.col      (col),
		.tick_div (tick_div_q),
		.cmd_push (cmd_push),
		.cmd_data (cmd_wdata),
		.cmd_full (cmd_full)
	);

	gsa_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(4)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wdata),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	gsa_back #(.GRID_CELLS(GRID_CELLS), .STEPS(STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_note (base_note_q),
		.cmd_rdata (cmd_rdata),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_data  (res_wdata),
		.res_full  (res_full)
	);

	gsa_fifo #(.WIDTH($bits(res_t)), .DEPTH(4)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign kind    = res_head.kind;
	assign led_row = res_head.led_row;
	assign led_col = res_head.led_col;
	assign color   = res_head.color;
	assign note    = res_head.note;
	assign last    = res_head.last;

	`ASSERT_NEVER(a_cmd_ovf, clk, arst_n, cmd_push && cmd_full)
	`ASSERT_NEVER(a_res_ovf, clk, arst_n, res_push && res_full)
	`ASSERT_ALWAYS(a_cmd_pop_ok, clk, arst_n, cmd_pop |-> !cmd_empty)
	`ASSERT_ALWAYS(a_res_steady, clk, arst_n, (!res_push && !(pop && !empty)) |=> $stable(empty))

endmodule

@@ tb/sv/grid_step_arpeggiator_tb.sv @@
// Self-checking testbench for grid_step_arpeggiator: directed key/tick table, then random
// phases over several divisor/base-note settings, checked against an in-bench predictor.
// Depends on gsa_pkg and the grid_step_arpeggiator RTL.
`timescale 1ns / 100ps

module grid_step_arpeggiator_tb;
	import gsa_pkg::*;

	localparam int GRID_CELLS = 48;
	localparam int STEPS      = 16;
	localparam int TOP_ROW    = (GRID_CELLS + 7) / 8 - 1;
	localparam int SETTLE     = 200;
	localparam int STALL_CAP  = 3000;
	localparam int LONG_HOLD  = 120;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [1:0]           mode;
	logic [2:0]           row;
	logic [3:0]           col;
	logic                 empty;
	logic                 pop;
	logic [1:0]           kind;
	logic [2:0]           led_row;
	logic [2:0]           led_col;
	logic [1:0]           color;
	logic [6:0]           note;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	grid_step_arpeggiator #(
		.GRID_CELLS(GRID_CELLS),
		.STEPS     (STEPS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.mode     (mode),
		.row      (row),
		.col      (col),
		.empty    (empty),
		.pop      (pop),
		.kind     (kind),
		.led_row  (led_row),
		.led_col  (led_col),
		.color    (color),
		.note     (note),
		.last     (last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [7:0] ticks_per_step;
	logic [6:0] bottom_note;
	logic [1:0] step_color [STEPS];
	logic [1:0] cell_color [GRID_CELLS];
	logic [3:0] step_at;
	logic [7:0] tick_acc;
	logic [1:0] shift_hue;
	logic [5:0] green_scan;
	logic [5:0] red_scan;
	logic [6:0] green_note;
	logic [6:0] red_note;

	res_t led_note_due [$];
	res_t head_due;
	int   errors;
	int   stall_left;
	int   quiet_cycles;
	bit   send_gaps;
	bit   take_gaps;
	bit   hold_off_req;

	typedef struct packed {
		logic [1:0] m;
		logic [2:0] r;
		logic [3:0] c;
		logic [3:0] reps;
		logic       typed;
		logic [1:0] ecol;
	} key_row_t;

	key_row_t key_plan [18] = '{
		'{MODE_DOWN, 3'd0, 4'd0, 4'd1, 1'b1, COLOR_GREEN},
		'{MODE_DOWN, 3'd5, 4'd7, 4'd1, 1'b1, COLOR_GREEN},
		'{MODE_DOWN, 3'd6, 4'd1, 4'd1, 1'b1, COLOR_GREEN},
		'{MODE_DOWN, 3'd7, 4'd7, 4'd1, 1'b1, COLOR_GREEN},
		'{MODE_DOWN, 3'd7, 4'd8, 4'd1, 1'b0, COLOR_OFF},
		'{MODE_DOWN, 3'd6, 4'd2, 4'd1, 1'b1, COLOR_RED},
		'{MODE_DOWN, 3'd2, 4'd3, 4'd1, 1'b1, COLOR_RED},
		'{MODE_UP,   3'd7, 4'd8, 4'd1, 1'b0, COLOR_OFF},
		'{MODE_DOWN, 3'd5, 4'd8, 4'd1, 1'b0, COLOR_OFF},
		'{MODE_DOWN, 3'd6, 4'd3, 4'd1, 1'b1, COLOR_YELLOW},
		'{MODE_DOWN, 3'd6, 4'd3, 4'd1, 1'b1, COLOR_OFF},
		'{MODE_DOWN, 3'd0, 4'd8, 4'd1, 1'b0, COLOR_OFF},
		'{MODE_UP,   3'd3, 4'd3, 4'd1, 1'b0, COLOR_OFF},
		'{MODE_DOWN, 3'd4, 4'd9, 4'd1, 1'b0, COLOR_OFF},
		'{MODE_DOWN, 3'd4, 4'd15, 4'd1, 1'b0, COLOR_OFF},
		'{2'd3,      3'd1, 4'd1, 4'd1, 1'b0, COLOR_OFF},
		'{MODE_TICK, 3'd0, 4'd0, 4'd6, 1'b0, COLOR_OFF},
		'{MODE_TICK, 3'd7, 4'd15, 4'd6, 1'b0, COLOR_OFF}
	};

	function automatic res_t mk_res(input logic [1:0] k, input logic [2:0] r,
			input logic [2:0] c, input logic [1:0] hue, input logic [6:0] n);
		res_t x;
		x.kind    = k;
		x.led_row = r;
		x.led_col = c;
		x.color   = hue;
		x.note    = n;
		x.last    = 1'b0;
		return x;
	endfunction

	function automatic logic [1:0] edit_color(input logic [1:0] v);
		if (shift_hue != COLOR_OFF && v != shift_hue)
			return shift_hue;
		return (v != COLOR_OFF) ? COLOR_OFF : COLOR_GREEN;
	endfunction

	function automatic logic [6:0] cell_note(input int idx);
		return 7'(int'(bottom_note) + (TOP_ROW - idx / 8) * 8 + idx % 8);
	endfunction

	// release the held note, then round-robin scan for the next enabled cell of this hue
	function automatic void sound_voice(input logic [1:0] hue, ref logic [5:0] scan,
			ref logic [6:0] held, ref res_t evq[$]);
		int p;
		int i;
		p = scan;
		if (held != 7'd0) begin
			evq.push_back(mk_res(KIND_OFF, 3'd0, 3'd0, COLOR_OFF, held));
			held = 7'd0;
		end
		if ((step_color[step_at] & hue) == hue) begin
			for (i = 0; i < GRID_CELLS; i++) begin
				p = (p + 1) % GRID_CELLS;
				if ((cell_color[p] & hue) == hue) begin
					scan = 6'(p);
					held = cell_note(p);
					evq.push_back(mk_res(KIND_ON, 3'd0, 3'd0, COLOR_OFF, held));
					return;
				end
			end
			scan = 6'(GRID_CELLS - 1);
		end
	endfunction

	function automatic void play_grid_event(input logic [1:0] m, input logic [2:0] r,
			input logic [3:0] c, ref res_t evq[$]);
		int idx;
		int d;
		int p;
		evq.delete();
		case (m)
			MODE_DOWN: begin
				if (c == SIDE_COL) begin
					shift_hue = (r == 3'd5) ? COLOR_YELLOW : (r == 3'd6) ? COLOR_GREEN :
						(r == 3'd7) ? COLOR_RED : COLOR_OFF;
				end else if (c < 4'd8) begin
					if (r >= 3'd6) begin
						idx = 8 * (int'(r) - 6) + int'(c);
						if (idx < STEPS) begin
							step_color[idx] = edit_color(step_color[idx]);
							evq.push_back(mk_res(KIND_LED, r, c[2:0], step_color[idx], 7'd0));
						end
					end else begin
						idx = 8 * int'(r) + int'(c);
						if (idx < GRID_CELLS) begin
							cell_color[idx] = edit_color(cell_color[idx]);
							evq.push_back(mk_res(KIND_LED, r, c[2:0], cell_color[idx], 7'd0));
						end
					end
				end
			end
			MODE_UP: begin
				if (c == SIDE_COL)
					shift_hue = COLOR_OFF;
			end
			MODE_TICK: begin
				d = (ticks_per_step == 8'd0) ? 256 : int'(ticks_per_step);
				if (int'(tick_acc) + 1 >= d) begin
					p = step_at;
					tick_acc = 8'd0;
					evq.push_back(mk_res(KIND_LED, 3'(6 + p / 8), 3'(p % 8), step_color[p], 7'd0));
					p = (p + 1) % STEPS;
					step_at = 4'(p);
					evq.push_back(mk_res(KIND_LED, 3'(6 + p / 8), 3'(p % 8), COLOR_YELLOW, 7'd0));
					sound_voice(COLOR_GREEN, green_scan, green_note, evq);
					sound_voice(COLOR_RED, red_scan, red_note, evq);
				end else begin
					tick_acc = tick_acc + 8'd1;
				end
			end
			default: ;
		endcase
		if (evq.size() > 0)
			evq[evq.size() - 1].last = 1'b1;
	endfunction

	function automatic void pick_event(output logic [1:0] m, output logic [2:0] r,
			output logic [3:0] c);
		int sel;
		sel = $urandom_range(0, 99);
		r = 3'($urandom_range(0, 7));
		c = 4'($urandom_range(0, 7));
		if (sel < 40) begin
			m = MODE_DOWN;
		end else if (sel < 50) begin
			m = MODE_DOWN;
			c = SIDE_COL;
		end else if (sel < 58) begin
			m = MODE_UP;
			c = SIDE_COL;
		end else if (sel < 94) begin
			m = MODE_TICK;
		end else begin
			m = 2'($urandom_range(0, 3));
			c = 4'($urandom_range(0, 15));
		end
	endfunction

	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= 40)
			$display("MISMATCH @%0t: %s", $time, what);
	endtask

	task automatic send_item(input logic [1:0] m, input logic [2:0] r, input logic [3:0] c,
			input logic typed, input logic [1:0] ecol);
		res_t evq[$];
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		row  <= r;
		col  <= c;
		do @(posedge clk); while (full);
		play_grid_event(m, r, c, evq);
		if (typed) begin
			evq.delete();
			evq.push_back(mk_res(KIND_LED, r, c[2:0], ecol, 7'd0));
			evq[0].last = 1'b1;
		end
		foreach (evq[k])
			led_note_due.push_back(evq[k]);
	endtask

	task automatic drain_and_settle();
		push <= 1'b0;
		while (led_note_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] div, input logic [6:0] base);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TICK_DIV;
		cfg_data  <= div;
		do @(posedge clk); while (!cfg_ready);
		ticks_per_step = div;
		cfg_index <= CFG_BASE_NOTE;
		cfg_data  <= {1'b0, base};
		do @(posedge clk); while (!cfg_ready);
		bottom_note = base;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count);
		logic [1:0] m;
		logic [2:0] r;
		logic [3:0] c;
		repeat (count) begin
			pick_event(m, r, c);
			send_item(m, r, c, 1'b0, COLOR_OFF);
		end
	endtask

	// result side
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (led_note_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat kind=%0d note=%0d", kind, note));
				end else begin
					head_due = led_note_due.pop_front();
					if (kind !== head_due.kind)
						flag_mismatch($sformatf("kind %0d, want %0d", kind, head_due.kind));
					if (led_row !== head_due.led_row)
						flag_mismatch($sformatf("led_row %0d, want %0d", led_row, head_due.led_row));
					if (led_col !== head_due.led_col)
						flag_mismatch($sformatf("led_col %0d, want %0d", led_col, head_due.led_col));
					if (color !== head_due.color)
						flag_mismatch($sformatf("color %0d, want %0d", color, head_due.color));
					if (note !== head_due.note)
						flag_mismatch($sformatf("note %0d, want %0d", note, head_due.note));
					if (last !== head_due.last)
						flag_mismatch($sformatf("last %0d, want %0d", last, head_due.last));
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = LONG_HOLD;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (take_gaps && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 3);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_CAP) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		mode         = MODE_DOWN;
		row          = 3'd0;
		col          = 4'd0;
		pop          = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_TICK_DIV;
		cfg_data     = 8'd0;
		errors       = 0;
		stall_left   = 0;
		quiet_cycles = 0;
		send_gaps    = 1'b1;
		take_gaps    = 1'b1;
		hold_off_req = 1'b0;

		ticks_per_step = TICK_DIV_RESET;
		bottom_note    = BASE_NOTE_RESET;
		foreach (step_color[i])
			step_color[i] = COLOR_OFF;
		foreach (cell_color[i])
			cell_color[i] = COLOR_OFF;
		step_at    = 4'd0;
		tick_acc   = 8'd0;
		shift_hue  = COLOR_OFF;
		green_scan = 6'(GRID_CELLS - 1);
		red_scan   = 6'(GRID_CELLS - 1);
		green_note = 7'd0;
		red_note   = 7'd0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (key_plan[i])
			repeat (key_plan[i].reps)
				send_item(key_plan[i].m, key_plan[i].r, key_plan[i].c,
					key_plan[i].typed, key_plan[i].ecol);

		drain_and_settle();
		configure(8'd1, 7'd36);
		run_random(70);

		drain_and_settle();
		configure(8'd255, 7'd80);
		run_random(25);

		// divisor drops below the accumulated tick count; base 0 reaches note zero
		drain_and_settle();
		configure(8'd2, 7'd0);
		run_random(70);

		drain_and_settle();
		configure(8'd3, 7'd17);
		run_random(70);

		drain_and_settle();
		configure(8'd1, 7'd80);
		hold_off_req = 1'b1;
		run_random(30);
		send_gaps = 1'b0;
		take_gaps = 1'b0;
		run_random(35);

		drain_and_settle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ grid_step_arpeggiator.f @@
+incdir+hw/rtl
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_ram.sv
hw/rtl/gsa_fifo.sv
hw/rtl/gsa_front.sv
hw/rtl/gsa_back.sv
hw/rtl/grid_step_arpeggiator.sv
tb/sv/grid_step_arpeggiator_tb.sv
